// ----- hdl/crrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the circle versus rotated rectangle collision core.
// No dependencies; used by every module of the core.
package crrc_pkg;

  localparam int GUARD_BITS = 8;
  localparam int GAIN_SHIFT = 22;
  localparam int ANGLE_W    = 34;
  localparam int TABLE_LEN  = 24;

  // Limit CORDIC gain inverse, Q30.
  localparam logic [29:0] GAIN_Q30   = 30'd652032874;
  localparam logic [15:0] ANGLE_BIAS = 16'd8192;
  localparam logic signed [14:0] REST_BIAS = 15'sd8192;

  typedef enum logic [1:0] {
    QUAD_ZERO  = 2'd0,
    QUAD_LEFT  = 2'd1,
    QUAD_HALF  = 2'd2,
    QUAD_RIGHT = 2'd3
  } quad_t;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// ----- hdl/crrc_front.sv -----
`timescale 1ns / 1ps
// Front end: offset, quarter-turn pre-rotation, angle remainder, gain multiply.
// Two register stages. Depends on crrc_pkg.
module crrc_front #(
  parameter int COORD_WIDTH = 24,
  parameter int XW = COORD_WIDTH + 11,
  parameter int SIDE_W = 7 * COORD_WIDTH - 1
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_stall,
  input  logic signed [COORD_WIDTH-1:0] rect_center_x,
  input  logic signed [COORD_WIDTH-1:0] rect_center_y,
  input  logic signed [COORD_WIDTH-1:0] pivot_x,
  input  logic signed [COORD_WIDTH-1:0] pivot_y,
  input  logic [15:0] turn_angle,
  input  logic [COORD_WIDTH-2:0] box_width,
  input  logic [COORD_WIDTH-2:0] box_height,
  input  logic signed [COORD_WIDTH-1:0] circle_x,
  input  logic signed [COORD_WIDTH-1:0] circle_y,
  input  logic [COORD_WIDTH-2:0] circle_rad,
  output logic dn_valid,
  input  logic dn_stall,
  output logic signed [XW-1:0] dn_x,
  output logic signed [XW-1:0] dn_y,
  output logic signed [crrc_pkg::ANGLE_W-1:0] dn_z,
  output logic [SIDE_W-1:0] dn_side
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = COORD_WIDTH + 32;

  logic a_valid, b_valid;
  logic a_hold, b_hold;
  logic signed [DW-1:0] a_x, a_y;
  logic signed [crrc_pkg::ANGLE_W-1:0] a_z, b_z;
  logic [SIDE_W-1:0] a_side, b_side;
  logic signed [XW-1:0] b_x, b_y;

  logic signed [DW-1:0] dx, dy, lox, loy, x_q, y_q;
  logic [15:0] shifted;
  crrc_pkg::quad_t quad;
  logic signed [14:0] rest;
  logic signed [crrc_pkg::ANGLE_W-1:0] z_q;
  logic signed [PW-1:0] prod_x, prod_y;

  assign b_hold = b_valid & dn_stall;
  assign a_hold = a_valid & b_hold;
  assign up_stall = a_hold;

  always_comb begin
    dx = DW'(circle_x) - DW'(rect_center_x);
    dy = DW'(circle_y) - DW'(rect_center_y);
    lox = DW'(rect_center_x) - DW'(pivot_x);
    loy = DW'(rect_center_y) - DW'(pivot_y);
    shifted = turn_angle + crrc_pkg::ANGLE_BIAS;
    quad = crrc_pkg::quad_t'(shifted[15:14]);
    rest = $signed({1'b0, shifted[13:0]}) - crrc_pkg::REST_BIAS;
    z_q = crrc_pkg::ANGLE_W'(rest) <<< 16;
    case (quad)
      crrc_pkg::QUAD_LEFT: begin
        x_q = -dy;
        y_q = dx;
      end
      crrc_pkg::QUAD_HALF: begin
        x_q = -dx;
        y_q = -dy;
      end
      crrc_pkg::QUAD_RIGHT: begin
        x_q = dy;
        y_q = -dx;
      end
      default: begin
        x_q = dx;
        y_q = dy;
      end
    endcase
  end

  always_comb begin
    prod_x = a_x * $signed({1'b0, crrc_pkg::GAIN_Q30});
    prod_y = a_y * $signed({1'b0, crrc_pkg::GAIN_Q30});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (!a_hold) a_valid <= up_valid;
      if (!b_hold) b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!a_hold) begin
      a_x <= x_q;
      a_y <= y_q;
      a_z <= z_q;
      a_side <= {rect_center_x, rect_center_y, lox, loy, box_width, box_height,
                 circle_rad};
    end
    if (!b_hold) begin
      b_x <= XW'(prod_x >>> crrc_pkg::GAIN_SHIFT);
      b_y <= XW'(prod_y >>> crrc_pkg::GAIN_SHIFT);
      b_z <= a_z;
      b_side <= a_side;
    end
  end

  assign dn_valid = b_valid;
  assign dn_x = b_x;
  assign dn_y = b_y;
  assign dn_z = b_z;
  assign dn_side = b_side;

endmodule

// ----- hdl/crrc_cell.sv -----
`timescale 1ns / 1ps
// One CORDIC micro-rotation cell with its own register stage.
// Depends on crrc_pkg for the arctangent table.
module crrc_cell #(
  parameter int XW = 35,
  parameter int SIDE_W = 167,
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_stall,
  input  logic signed [XW-1:0] up_x,
  input  logic signed [XW-1:0] up_y,
  input  logic signed [crrc_pkg::ANGLE_W-1:0] up_z,
  input  logic [SIDE_W-1:0] up_side,
  output logic dn_valid,
  input  logic dn_stall,
  output logic signed [XW-1:0] dn_x,
  output logic signed [XW-1:0] dn_y,
  output logic signed [crrc_pkg::ANGLE_W-1:0] dn_z,
  output logic [SIDE_W-1:0] dn_side
);

  localparam logic signed [crrc_pkg::ANGLE_W-1:0] ATAN =
    $signed({{(crrc_pkg::ANGLE_W-32){1'b0}}, crrc_pkg::ATAN_TURN32[STEP]});

  logic valid, hold;
  logic signed [XW-1:0] x, y, xs, ys, x_next, y_next;
  logic signed [crrc_pkg::ANGLE_W-1:0] z, z_next;
  logic [SIDE_W-1:0] side;

  assign hold = valid & dn_stall;
  assign up_stall = hold;

  always_comb begin
    xs = up_x >>> STEP;
    ys = up_y >>> STEP;
    if (!up_z[crrc_pkg::ANGLE_W-1]) begin
      x_next = up_x - ys;
      y_next = up_y + xs;
      z_next = up_z - ATAN;
    end else begin
      x_next = up_x + ys;
      y_next = up_y - xs;
      z_next = up_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      side <= up_side;
    end
  end

  assign dn_valid = valid;
  assign dn_x = x;
  assign dn_y = y;
  assign dn_z = z;
  assign dn_side = side;

endmodule

// ----- hdl/crrc_back.sv -----
`timescale 1ns / 1ps
// Back end: rounding, clamp to the box, saturated squares, compare with radius squared.
// Four register stages, the last is the result register. Depends on crrc_pkg.
module crrc_back #(
  parameter int COORD_WIDTH = 24,
  parameter int XW = COORD_WIDTH + 11,
  parameter int SIDE_W = 7 * COORD_WIDTH - 1
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_stall,
  input  logic signed [XW-1:0] up_x,
  input  logic signed [XW-1:0] up_y,
  input  logic [SIDE_W-1:0] up_side,
  output logic dn_valid,
  input  logic dn_stall,
  output logic hit
);

  localparam int W  = COORD_WIDTH;
  localparam int UW = COORD_WIDTH + 5;
  localparam int RW = 2 * (COORD_WIDTH - 1);
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (crrc_pkg::GUARD_BITS - 1);

  function automatic logic [62:0] sq_sat(input logic signed [63:0] d);
    logic [63:0] m;
    begin
      m = d[63] ? 64'(-d) : 64'(d);
      if (|m[63:31]) sq_sat = 63'(1) << 62;
      else sq_sat = 63'(m[30:0]) * 63'(m[30:0]);
    end
  endfunction

  logic signed [W-1:0] cx, cy;
  logic signed [W:0] lox, loy;
  logic [W-2:0] bw, bh, rad;

  logic v1, v2, v3, v4;
  logic h1, h2, h3, h4;
  logic signed [UW-1:0] s1_ux, s1_uy, s1_lox, s1_loy, s1_hix, s1_hiy;
  logic [W-2:0] s1_r, s2_r;
  logic signed [UW-1:0] s2_dx, s2_dy, dx_next, dy_next;
  logic [62:0] s3_sqx, s3_sqy;
  logic [RW-1:0] s3_r2;
  logic hit_q, hit_next;

  assign {cx, cy, lox, loy, bw, bh, rad} = up_side;

  assign h4 = v4 & dn_stall;
  assign h3 = v3 & h4;
  assign h2 = v2 & h3;
  assign h1 = v1 & h2;
  assign up_stall = h1;

  always_comb begin
    if (s1_ux < s1_lox) dx_next = s1_ux - s1_lox;
    else if (s1_ux > s1_hix) dx_next = s1_ux - s1_hix;
    else dx_next = '0;
    if (s1_uy < s1_loy) dy_next = s1_uy - s1_loy;
    else if (s1_uy > s1_hiy) dy_next = s1_uy - s1_hiy;
    else dy_next = '0;
    hit_next = (64'(s3_sqx) + 64'(s3_sqy)) < 64'(s3_r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (!h1) v1 <= up_valid;
      if (!h2) v2 <= v1;
      if (!h3) v3 <= v2;
      if (!h4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (!h1) begin
      s1_ux <= UW'((up_x + HALF) >>> crrc_pkg::GUARD_BITS) + UW'(cx);
      s1_uy <= UW'((up_y + HALF) >>> crrc_pkg::GUARD_BITS) + UW'(cy);
      s1_lox <= UW'(lox);
      s1_loy <= UW'(loy);
      s1_hix <= UW'(lox) + UW'($signed({1'b0, bw}));
      s1_hiy <= UW'(loy) + UW'($signed({1'b0, bh}));
      s1_r <= rad;
    end
    if (!h2) begin
      s2_dx <= dx_next;
      s2_dy <= dy_next;
      s2_r <= s1_r;
    end
    if (!h3) begin
      s3_sqx <= sq_sat(64'(s2_dx));
      s3_sqy <= sq_sat(64'(s2_dy));
      s3_r2 <= s2_r * s2_r;
    end
    if (!h4) begin
      hit_q <= hit_next;
    end
  end

  assign dn_valid = v4;
  assign hit = hit_q;

endmodule

// ----- hdl/circle_rotated_rect_collision_core.sv -----
`timescale 1ns / 1ps
// Circle versus rotated rectangle collision core, top level.
// Depends on crrc_pkg, crrc_front, crrc_cell and crrc_back.
//
// Usage:
//   Request channel: req_valid / req_stall with the query fields as ports.
//   A request is taken at a clock edge with req_valid high and req_stall low.
//   Result channel: res_valid / res_stall with the hit flag.
//   Coordinates are signed Q.8, sizes and radius unsigned Q.8, turn_angle is
//   a fraction of a full turn in 1/65536 steps.
// Pipeline:
//   A request passes two front stages (offset and gain multiply), one CORDIC
//   cell per step and four back stages (round, clamp, square, compare).
//   Throughput is one request per cycle while res_stall does not hold the pipeline.
// Stall:
//   Each stage holds while its successor is full and stalled; empty stages
//   keep filling, so req_stall rises only once every stage holds a request.
// Reset:
//   rst is synchronous; it empties the pipeline and drops res_valid.
module circle_rotated_rect_collision_core #(
  parameter int COORD_WIDTH = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  logic signed [COORD_WIDTH-1:0] rect_center_x,
  input  logic signed [COORD_WIDTH-1:0] rect_center_y,
  input  logic signed [COORD_WIDTH-1:0] pivot_x,
  input  logic signed [COORD_WIDTH-1:0] pivot_y,
  input  logic [15:0] turn_angle,
  input  logic [COORD_WIDTH-2:0] box_width,
  input  logic [COORD_WIDTH-2:0] box_height,
  input  logic signed [COORD_WIDTH-1:0] circle_x,
  input  logic signed [COORD_WIDTH-1:0] circle_y,
  input  logic [COORD_WIDTH-2:0] circle_rad,
  output logic res_valid,
  input  logic res_stall,
  output logic hit
);

  localparam int XW = COORD_WIDTH + 11;
  localparam int SIDE_W = 7 * COORD_WIDTH - 1;
  localparam int DEPTH = CORDIC_STEPS + 6;
  localparam int CW = $clog2(DEPTH + 1) + 1;

  logic ch_valid [CORDIC_STEPS+1];
  logic ch_stall [CORDIC_STEPS+1];
  logic signed [XW-1:0] ch_x [CORDIC_STEPS+1];
  logic signed [XW-1:0] ch_y [CORDIC_STEPS+1];
  logic signed [crrc_pkg::ANGLE_W-1:0] ch_z [CORDIC_STEPS+1];
  logic [SIDE_W-1:0] ch_side [CORDIC_STEPS+1];

  crrc_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .XW(XW),
    .SIDE_W(SIDE_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .up_valid(req_valid),
    .up_stall(req_stall),
    .rect_center_x(rect_center_x),
    .rect_center_y(rect_center_y),
    .pivot_x(pivot_x),
    .pivot_y(pivot_y),
    .turn_angle(turn_angle),
    .box_width(box_width),
    .box_height(box_height),
    .circle_x(circle_x),
    .circle_y(circle_y),
    .circle_rad(circle_rad),
    .dn_valid(ch_valid[0]),
    .dn_stall(ch_stall[0]),
    .dn_x(ch_x[0]),
    .dn_y(ch_y[0]),
    .dn_z(ch_z[0]),
    .dn_side(ch_side[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    crrc_cell #(
      .XW(XW),
      .SIDE_W(SIDE_W),
      .STEP(k)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .up_valid(ch_valid[k]),
      .up_stall(ch_stall[k]),
      .up_x(ch_x[k]),
      .up_y(ch_y[k]),
      .up_z(ch_z[k]),
      .up_side(ch_side[k]),
      .dn_valid(ch_valid[k+1]),
      .dn_stall(ch_stall[k+1]),
      .dn_x(ch_x[k+1]),
      .dn_y(ch_y[k+1]),
      .dn_z(ch_z[k+1]),
      .dn_side(ch_side[k+1])
    );
  end

  crrc_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .XW(XW),
    .SIDE_W(SIDE_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .up_valid(ch_valid[CORDIC_STEPS]),
    .up_stall(ch_stall[CORDIC_STEPS]),
    .up_x(ch_x[CORDIC_STEPS]),
    .up_y(ch_y[CORDIC_STEPS]),
    .up_side(ch_side[CORDIC_STEPS]),
    .dn_valid(res_valid),
    .dn_stall(res_stall),
    .hit(hit)
  );

  // requests in flight, for checking only
  logic [CW-1:0] inflight, inflight_next;
  logic req_take, res_take;

  assign req_take = req_valid & ~req_stall;
  assign res_take = res_valid & ~res_stall;

  always_comb begin
    inflight_next = inflight;
    if (req_take && !res_take) inflight_next = inflight + CW'(1);
    else if (!req_take && res_take) inflight_next = inflight - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  a_stall_from_output: assert property (@(posedge clk)
    req_stall |-> (res_valid && res_stall))
    else $error("request stalled while result side is free");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (inflight != '0))
    else $error("result shown with no request in flight");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for circle_rotated_rect_collision_core: random and corner-case
// collision requests, a bit-exact CORDIC hit predictor, random request gaps and result stalls.
// Depends on crrc_pkg (quad_t) and the core RTL.
module tb_top;

  localparam int CW = 24;
  localparam int STEPS = 16;
  localparam int Q8 = 256;
  localparam longint GAIN_INV = 64'd652032874;
  localparam longint ATAN_STEP [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [CW-1:0] rect_center_x;
    logic signed [CW-1:0] rect_center_y;
    logic signed [CW-1:0] pivot_x;
    logic signed [CW-1:0] pivot_y;
    logic [15:0] turn_angle;
    logic [CW-2:0] box_width;
    logic [CW-2:0] box_height;
    logic signed [CW-1:0] circle_x;
    logic signed [CW-1:0] circle_y;
    logic [CW-2:0] circle_rad;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic res_valid;
  logic res_stall = 1'b0;
  logic hit;
  query_t req_item = '0;
  logic req_held = 1'b0;

  query_t pending_reqs[$];
  bit expected_hits[$];
  int total_reqs = 0;
  int taken_cnt = 0;
  int checked_cnt = 0;
  int hits_seen = 0;
  int fail_cnt = 0;
  logic calm;

  assign calm = (taken_cnt >= 200) && (taken_cnt < 330);

  circle_rotated_rect_collision_core #(
    .COORD_WIDTH(CW),
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rect_center_x(req_item.rect_center_x),
    .rect_center_y(req_item.rect_center_y),
    .pivot_x(req_item.pivot_x),
    .pivot_y(req_item.pivot_y),
    .turn_angle(req_item.turn_angle),
    .box_width(req_item.box_width),
    .box_height(req_item.box_height),
    .circle_x(req_item.circle_x),
    .circle_y(req_item.circle_y),
    .circle_rad(req_item.circle_rad),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .hit(hit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] square_sat(longint d);
    longint m;
    m = (d < 0) ? -d : d;
    if (m >= 64'sd2147483648) return 64'h4000_0000_0000_0000;
    return m * m;
  endfunction

  function automatic longint clamp_span(longint v, longint lo, longint span);
    if (v < lo) return lo;
    if (v > lo + span) return lo + span;
    return v;
  endfunction

  function automatic bit circle_meets_box(query_t q);
    longint cx, cy, px, py, w, h, dx, dy, x, y, z, t, xs, ys, rest, ux, uy, nx, ny;
    logic [15:0] shifted;
    crrc_pkg::quad_t quad;
    logic [63:0] dist2, rad2;
    cx = q.rect_center_x;
    cy = q.rect_center_y;
    px = q.pivot_x;
    py = q.pivot_y;
    w = q.box_width;
    h = q.box_height;
    dx = longint'(q.circle_x) - cx;
    dy = longint'(q.circle_y) - cy;
    // quarter-turn pre-rotation, remainder within +/- 45 degrees
    shifted = q.turn_angle + 16'd8192;
    quad = crrc_pkg::quad_t'(shifted[15:14]);
    rest = shifted[13:0];
    rest = rest - 8192;
    case (quad)
      crrc_pkg::QUAD_LEFT: begin
        x = -dy; y = dx;
      end
      crrc_pkg::QUAD_HALF: begin
        x = -dx; y = -dy;
      end
      crrc_pkg::QUAD_RIGHT: begin
        x = dy; y = -dx;
      end
      default: begin
        x = dx; y = dy;
      end
    endcase
    x = (x * GAIN_INV) >>> 22;
    y = (y * GAIN_INV) >>> 22;
    z = rest * 65536;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        t = x - ys; y = y + xs; x = t;
        z = z - ATAN_STEP[i];
      end else begin
        t = x + ys; y = y - xs; x = t;
        z = z + ATAN_STEP[i];
      end
    end
    ux = ((x + 128) >>> 8) + cx;
    uy = ((y + 128) >>> 8) + cy;
    nx = clamp_span(ux, cx - px, w);
    ny = clamp_span(uy, cy - py, h);
    dist2 = square_sat(ux - nx) + square_sat(uy - ny);
    rad2 = longint'(q.circle_rad) * longint'(q.circle_rad);
    return dist2 < rad2;
  endfunction

  task automatic add_query(input int cx, input int cy, input int px, input int py,
                           input int ang, input int w, input int h,
                           input int qx, input int qy, input int r);
    query_t q;
    q.rect_center_x = cx;
    q.rect_center_y = cy;
    q.pivot_x = px;
    q.pivot_y = py;
    q.turn_angle = ang;
    q.box_width = w;
    q.box_height = h;
    q.circle_x = qx;
    q.circle_y = qy;
    q.circle_rad = r;
    pending_reqs.push_back(q);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_held) begin
      req_valid <= 1'b1;
    end else if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
      req_item <= pending_reqs.pop_front();
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    res_stall <= !rst && !calm && ($urandom_range(99) < 27);
  end

  // acceptance, prediction and result check
  always @(posedge clk) begin
    req_held <= !rst && req_valid && req_stall;
    if (!rst && req_valid && !req_stall) begin
      expected_hits.push_back(circle_meets_box(req_item));
      taken_cnt <= taken_cnt + 1;
    end
    if (!rst && res_valid && !res_stall) begin
      if (expected_hits.size() == 0) begin
        $error("unexpected result: hit=%0b with no request outstanding", hit);
        fail_cnt <= fail_cnt + 1;
      end else begin
        if (hit !== expected_hits[0]) begin
          $error("field hit: expected %0b, actual %0b (result %0d)",
                 expected_hits[0], hit, checked_cnt);
          fail_cnt <= fail_cnt + 1;
        end
        void'(expected_hits.pop_front());
        checked_cnt <= checked_cnt + 1;
        hits_seen <= hits_seen + (hit === 1'b1);
      end
    end
  end

  initial begin
    int angs [10];
    query_t q;
    int sh, span, w, h, pick;
    angs = '{0, 8191, 8192, 16383, 16384, 24576, 32768, 49152, 57343, 65535};
    // corner cases
    add_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_query(0, 0, 10*Q8, 5*Q8, 0, 20*Q8, 10*Q8, 0, 0, Q8);
    foreach (angs[i])
      add_query(0, 0, 10*Q8, 5*Q8, angs[i], 20*Q8, 10*Q8, 15*Q8, 0, 6*Q8);
    add_query(0, 0, 0, 0, 0, 0, 0, 3*Q8, 4*Q8, 5*Q8);
    add_query(0, 0, 0, 0, 0, 0, 0, 3*Q8, 4*Q8, 5*Q8 + 1);
    add_query(100*Q8, -50*Q8, 0, 0, 4000, 30*Q8, 0, 110*Q8, -50*Q8, 2*Q8);
    add_query(0, 0, 4*Q8, 4*Q8, 1000, 8*Q8, 8*Q8, Q8, Q8, 0);
    add_query(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 65535,
              23'h7FFFFF, 23'h7FFFFF, 24'h800000, 24'h800000, 23'h7FFFFF);
    add_query(24'h800000, 24'h800000, 24'h800000, 24'h800000, 0,
              0, 0, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
    add_query(24'h800000, 24'h7FFFFF, 0, 0, 32768, 23'h7FFFFF, 0,
              24'h7FFFFF, 24'h800000, 23'h7FFFFF);
    add_query(0, 0, 24'h3FFFFF, 24'h3FFFFF, 12345, 23'h7FFFFF, 23'h7FFFFF, 0, 0, 23'h7FFFFF);
    add_query(-20*Q8, 7*Q8, -6*Q8, 3*Q8, 40000, 5*Q8, 9*Q8, -14*Q8, 9*Q8, 3*Q8);
    // random requests: mostly circles placed near their box, some fully random
    for (int n = 0; n < 550; n++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        q.rect_center_x = $urandom;
        q.rect_center_y = $urandom;
        q.pivot_x = $urandom;
        q.pivot_y = $urandom;
        q.turn_angle = $urandom;
        q.box_width = $urandom;
        q.box_height = $urandom;
        q.circle_x = $urandom;
        q.circle_y = $urandom;
        q.circle_rad = $urandom;
      end else begin
        sh = $urandom_range(18, 4);
        span = 1 << sh;
        w = $urandom_range(span);
        h = $urandom_range(span);
        q.rect_center_x = $urandom_range(1) ? $urandom : int'($urandom_range(2*span)) - span;
        q.rect_center_y = $urandom_range(1) ? $urandom : int'($urandom_range(2*span)) - span;
        q.pivot_x = int'($urandom_range(w + span/2)) - span/4;
        q.pivot_y = int'($urandom_range(h + span/2)) - span/4;
        q.turn_angle = $urandom_range(65535);
        q.box_width = w;
        q.box_height = h;
        q.circle_x = q.rect_center_x + int'($urandom_range(4*span)) - 2*span;
        q.circle_y = q.rect_center_y + int'($urandom_range(4*span)) - 2*span;
        q.circle_rad = ($urandom_range(9) == 0) ? 0 : $urandom_range(2*span);
      end
      pending_reqs.push_back(q);
    end
    total_reqs = pending_reqs.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (taken_cnt == total_reqs);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d collision requests (%0d hits, %0d misses) over all quarter-turns,",
             checked_cnt, hits_seen, checked_cnt - hits_seen);
    $display("field extremes, empty boxes and zero radii, with stalls on both channels.");
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d of %0d requests taken, %0d results pending",
             taken_cnt, total_reqs, expected_hits.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
